@@ sv/sm4_block_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// SM4 assertion macros
// Shorthand for clocked, reset-qualified checks used inside the SM4 modules.
// ----------------------------------------------------------------------------
`ifndef SM4_BLOCK_CIPHER_ASSERT_SVH
`define SM4_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SM4_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SM4_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sm4_pkg.sv @@
// ----------------------------------------------------------------------------
// SM4 package
// Shared types, constants, S-box and round constant helper for the SM4 core.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned RND_W      = $clog2(NUM_ROUNDS);
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // Key register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 3'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_FINISH
  } sm4_state_e;

  typedef enum logic {
    MIX_DATA,
    MIX_KEY
  } sm4_mix_e;

  localparam word_t FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Round constant CK[i]: byte j is (4*i + j) * 7 mod 256, first byte on top
  function automatic word_t ck_word(input logic [RND_W-1:0] idx);
    word_t      v;
    logic [7:0] t;
    v = '0;
    for (int j = 0; j < 4; j++) begin
      t = {1'b0, idx, 2'b00} + 8'(j);
      v[WORD_W-1-8*j -: 8] = 8'(t * 8'd7);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/sm4_req_if.sv @@
// ----------------------------------------------------------------------------
// SM4 request channel
// Valid/ready channel carrying one block and its encrypt/decrypt selector.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm4_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] text_word0;
  logic [31:0] text_word1;
  logic [31:0] text_word2;
  logic [31:0] text_word3;

  modport source (
    output valid, req_type, text_word0, text_word1, text_word2, text_word3,
    input  ready
  );

  modport sink (
    input  valid, req_type, text_word0, text_word1, text_word2, text_word3,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/sm4_rsp_if.sv @@
// ----------------------------------------------------------------------------
// SM4 response channel
// Valid/ready channel carrying one result block.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm4_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;

  modport source (
    output valid, out_word0, out_word1, out_word2, out_word3,
    input  ready
  );

  modport sink (
    input  valid, out_word0, out_word1, out_word2, out_word3,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/sm4_round_unit.sv @@
// ----------------------------------------------------------------------------
// SM4 round function unit
// Byte-wise S-box followed by the data or key-schedule linear transform.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_round_unit (
  input  logic [31:0]       din_i,
  input  sm4_pkg::sm4_mix_e mode_i,
  output logic [31:0]       dout_o
);
  import sm4_pkg::*;

  word_t b;

  always_comb begin
    b = {SBOX[din_i[31:24]], SBOX[din_i[23:16]], SBOX[din_i[15:8]], SBOX[din_i[7:0]]};
  end

  always_comb begin
    unique case (mode_i)
      MIX_KEY: begin
        // b ^ rol13 ^ rol23
        dout_o = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
      end
      default: begin
        // b ^ rol2 ^ rol10 ^ rol18 ^ rol24
        dout_o = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                   ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sm4_block_cipher.sv @@
// Sequencing: a block accepted with the key already expanded runs the rounds
//   and is then loaded into the result register; after a key write the first
//   block runs the key expansion before its rounds.
// Occupancy: a new block is taken only once the last result is loaded, as
//   the single shared round unit does one round (or one key step) per cycle.
// Reset: state machine idles, key registers clear, the round keys are marked
//   unexpanded and the result register empties.
// ----------------------------------------------------------------------------
// SM4 block cipher
// Iterative SM4 core: on-demand key schedule and 32 rounds on a shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_block_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sm4_pkg::WORD_W-1:0]     cfg_data_i,
  sm4_req_if.sink                        req_i,
  sm4_rsp_if.source                      rsp_o
);
  import sm4_pkg::*;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS - 1);

  sm4_state_e       state_q, state_d;
  logic [RND_W-1:0] cnt_q;
  logic             kexp_q;
  logic             dec_q;
  logic             rsp_valid_q;
  word_t            key_q [4];
  word_t            txt_q [4];
  word_t            w_q   [4];
  word_t            out_q [4];
  word_t            rk_q  [NUM_ROUNDS];

  logic             req_accept;
  logic             out_load;
  logic             cfg_hit;
  logic             last_step;
  logic [RND_W-1:0] rk_idx;
  sm4_mix_e         unit_mode;
  word_t            unit_din;
  word_t            unit_dout;
  word_t            new_word;

  // Shared round unit
  always_comb begin
    rk_idx    = dec_q ? ~cnt_q : cnt_q;
    unit_mode = (state_q == ST_EXPAND) ? MIX_KEY : MIX_DATA;
    unit_din  = w_q[1] ^ w_q[2] ^ w_q[3]
              ^ ((state_q == ST_EXPAND) ? ck_word(cnt_q) : rk_q[rk_idx]);
    new_word  = w_q[0] ^ unit_dout;
  end

  sm4_round_unit u_round (
    .din_i  (unit_din),
    .mode_i (unit_mode),
    .dout_o (unit_dout)
  );

  // Handshake and control outputs
  always_comb begin
    req_accept = req_i.valid && (state_q == ST_IDLE);
    out_load   = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready);
    last_step  = (cnt_q == LAST_RND);
    cfg_hit    = cfg_we_i && (cfg_idx_i == CFG_KEY_WORD0 || cfg_idx_i == CFG_KEY_WORD1
                           || cfg_idx_i == CFG_KEY_WORD2 || cfg_idx_i == CFG_KEY_WORD3);
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.out_word0 = out_q[0];
  assign rsp_o.out_word1 = out_q[1];
  assign rsp_o.out_word2 = out_q[2];
  assign rsp_o.out_word3 = out_q[3];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          state_d = kexp_q ? ST_ROUND : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (last_step) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (last_step) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      kexp_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (req_accept) begin
        cnt_q <= '0;
      end else if (state_q == ST_EXPAND || state_q == ST_ROUND) begin
        // wraps to zero at the end of expansion, ready for the rounds
        cnt_q <= cnt_q + 1'b1;
      end
      if (cfg_hit) begin
        kexp_q <= 1'b0;
      end else if (state_q == ST_EXPAND && last_step) begin
        kexp_q <= 1'b1;
      end
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY_WORD0: key_q[0] <= cfg_data_i;
          CFG_KEY_WORD1: key_q[1] <= cfg_data_i;
          CFG_KEY_WORD2: key_q[2] <= cfg_data_i;
          CFG_KEY_WORD3: key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      dec_q    <= req_i.req_type;
      txt_q[0] <= req_i.text_word0;
      txt_q[1] <= req_i.text_word1;
      txt_q[2] <= req_i.text_word2;
      txt_q[3] <= req_i.text_word3;
      if (kexp_q) begin
        w_q[0] <= req_i.text_word0;
        w_q[1] <= req_i.text_word1;
        w_q[2] <= req_i.text_word2;
        w_q[3] <= req_i.text_word3;
      end else begin
        for (int i = 0; i < 4; i++) begin
          w_q[i] <= key_q[i] ^ FK[i];
        end
      end
    end else if (state_q == ST_EXPAND) begin
      rk_q[cnt_q] <= new_word;
      if (last_step) begin
        // swap the key words out for the held block
        w_q <= txt_q;
      end else begin
        w_q[0] <= w_q[1];
        w_q[1] <= w_q[2];
        w_q[2] <= w_q[3];
        w_q[3] <= new_word;
      end
    end else if (state_q == ST_ROUND) begin
      w_q[0] <= w_q[1];
      w_q[1] <= w_q[2];
      w_q[2] <= w_q[3];
      w_q[3] <= new_word;
    end
    if (out_load) begin
      out_q[0] <= w_q[3];
      out_q[1] <= w_q[2];
      out_q[2] <= w_q[1];
      out_q[3] <= w_q[0];
    end
  end

`include "sm4_block_cipher_assert.svh"

  `SM4_ASSERT_NEXT(a_accept_clears_cnt, req_accept, cnt_q == '0, "round count not cleared on accept")
  `SM4_ASSERT_NEXT(a_expand_marks_done, state_q == ST_EXPAND && last_step && !cfg_we_i, kexp_q, "key schedule not marked done")
  `SM4_ASSERT_NEXT(a_expand_leads_round, state_q == ST_EXPAND, state_q == ST_EXPAND || state_q == ST_ROUND, "expansion left to a wrong state")
  `SM4_ASSERT_NEXT(a_finish_loads_out, out_load, rsp_valid_q && state_q == ST_IDLE, "result not presented after finish")

endmodule

`default_nettype wire
